FILE: design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the update sequencer RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define UDS_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
// expression must never be true outside reset
`define UDS_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");
`else
`define UDS_ASSERT(lbl, clk, rst_n, prop)
`define UDS_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

FILE: design/upd_seq_pkg.sv
// ---------------------------------------------------------------------------
// Update sequencer package
// Shared types, codes and constants for the firmware update sequencer.
// ---------------------------------------------------------------------------
package upd_seq_pkg;

	localparam int unsigned FIELD_W       = 32;
	localparam int unsigned SIZE_BITS_DEF = 32;
	localparam int unsigned PCT_W         = 7;
	localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

	localparam logic [1:0] OP_BEGIN = 2'd0;
	localparam logic [1:0] OP_STEP  = 2'd1;
	localparam logic [1:0] OP_ABORT = 2'd2;

	localparam logic [1:0] DL_PROGRESS = 2'd0;
	localparam logic [1:0] DL_COMPLETE = 2'd1;
	localparam logic [1:0] DL_FAILED   = 2'd2;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_CHECK  = 3'd1,
		PH_DOWN   = 3'd2,
		PH_VERIFY = 3'd3,
		PH_APPLY  = 3'd4,
		PH_DONE   = 3'd5,
		PH_ERROR  = 3'd6
	} phase_t;

	typedef enum logic [3:0] {
		E_NONE           = 4'd0,
		E_BUSY           = 4'd1,
		E_INVALID_REQ    = 4'd2,
		E_INVALID_RESUME = 4'd3,
		E_CHECK          = 4'd4,
		E_DOWNLOAD       = 4'd5,
		E_VERIFY         = 4'd6,
		E_APPLY          = 4'd7,
		E_ABORTED        = 4'd8
	} error_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV,
		ST_FIN
	} ctrl_state_t;

	typedef struct packed {
		logic [1:0]         opcode;
		logic               request_valid;
		logic [FIELD_W-1:0] resume_offset;
		logic               transport_ok;
		logic [FIELD_W-1:0] reported_total;
		logic [FIELD_W-1:0] reported_bytes;
		logic [1:0]         download_result;
	} req_item_t;

	typedef struct packed {
		logic               accepted;
		logic [2:0]         phase;
		logic [3:0]         error_code;
		logic [3:0]         last_error_code;
		logic [FIELD_W-1:0] bytes_done;
		logic [FIELD_W-1:0] image_total;
		logic [PCT_W-1:0]   progress_percent;
		logic               busy_flag;
		logic               transport_abort;
	} rsp_item_t;

	// controller -> datapath
	typedef struct packed {
		logic load_item;
		logic div_start;
		logic commit;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic div_done;
	} dp_stat_t;

endpackage

FILE: design/upd_if.sv
// ---------------------------------------------------------------------------
// Update sequencer channels
// Valid/ready channels for command items and result items.
// ---------------------------------------------------------------------------
interface upd_req_if;
	logic                   valid;
	logic                   ready;
	upd_seq_pkg::req_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface upd_rsp_if;
	logic                   valid;
	logic                   ready;
	upd_seq_pkg::rsp_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: design/upd_pct_div.sv
// ---------------------------------------------------------------------------
// Percentage divider
// Serial restoring division giving floor(b*100/t), saturated at 100.
// ---------------------------------------------------------------------------
module upd_pct_div #(
	parameter int unsigned SIZE_BITS = upd_seq_pkg::SIZE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [SIZE_BITS-1:0]          num_b,
	input  logic [SIZE_BITS-1:0]          den_t,
	output logic                          done,
	output logic [upd_seq_pkg::PCT_W-1:0] pct
);
	import upd_seq_pkg::*;

	localparam int unsigned PROD_W = SIZE_BITS + PCT_W;
	localparam int unsigned CNT_W  = $clog2(PCT_W + 1);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [SIZE_BITS-1:0] rem_q;
	logic [SIZE_BITS-1:0] den_q;
	logic [PCT_W-1:0]     low_q;
	logic [PCT_W-1:0]     quo_q;
	logic                 sat_q;

	logic [PROD_W-1:0]    b_ext;
	logic [PROD_W-1:0]    prod;
	logic [SIZE_BITS:0]   rem_ext;
	logic [SIZE_BITS:0]   diff;
	logic                 ge;

	// b*100 = b*64 + b*32 + b*4
	assign b_ext = PROD_W'(num_b);
	assign prod  = (b_ext << 6) + (b_ext << 5) + (b_ext << 2);

	assign rem_ext = {rem_q, low_q[PCT_W-1]};
	assign diff    = rem_ext - {1'b0, den_q};
	assign ge      = (rem_ext >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(PCT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// b < t keeps the quotient below 128, so seven steps cover it
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= prod[PROD_W-1:PCT_W];
			low_q <= prod[PCT_W-1:0];
			den_q <= den_t;
			quo_q <= '0;
			sat_q <= (num_b >= den_t);
		end else if (busy_q) begin
			rem_q <= ge ? diff[SIZE_BITS-1:0] : rem_ext[SIZE_BITS-1:0];
			low_q <= {low_q[PCT_W-2:0], 1'b0};
			quo_q <= {quo_q[PCT_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign pct  = sat_q ? PCT_FULL : quo_q;

endmodule

FILE: design/upd_dp.sv
// ---------------------------------------------------------------------------
// Update sequencer datapath
// Run state registers, step decisions, progress divider and result register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module upd_dp #(
	parameter int unsigned SIZE_BITS = upd_seq_pkg::SIZE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  upd_seq_pkg::req_item_t req_data,
	input  upd_seq_pkg::dp_cmd_t   cmd,
	output upd_seq_pkg::dp_stat_t  stat,
	output upd_seq_pkg::rsp_item_t rsp_data
);
	import upd_seq_pkg::*;

	req_item_t            item_q;
	rsp_item_t            rsp_q;
	phase_t               phase_q, phase_n;
	error_t               err_q, err_n;
	error_t               last_q, last_n;
	error_t               fail_code;
	logic [SIZE_BITS-1:0] resume_q, resume_n;
	logic [SIZE_BITS-1:0] bytes_q, bytes_n;
	logic [SIZE_BITS-1:0] total_q, total_n;
	logic [PCT_W-1:0]     progress_q, prog_n;

	logic [SIZE_BITS-1:0] ro, rt, rb, t_eff, b_eff, div_b, div_t;
	logic [PCT_W-1:0]     pct, prog_max;
	logic                 busy_now, busy_n, dl_failed, early_fail;
	logic                 fail, acc, abort_n;

	assign ro = SIZE_BITS'(item_q.resume_offset);
	assign rt = SIZE_BITS'(item_q.reported_total);
	assign rb = SIZE_BITS'(item_q.reported_bytes);

	assign busy_now = (phase_q == PH_CHECK) || (phase_q == PH_DOWN) ||
		(phase_q == PH_VERIFY) || (phase_q == PH_APPLY);
	assign busy_n = (phase_n == PH_CHECK) || (phase_n == PH_DOWN) ||
		(phase_n == PH_VERIFY) || (phase_n == PH_APPLY);

	// download: a nonzero reported total replaces the known one,
	// byte count never moves backward
	assign t_eff     = (rt != '0) ? rt : total_q;
	assign b_eff     = (rb < bytes_q) ? bytes_q : rb;
	assign dl_failed = item_q.download_result[1];
	assign early_fail = ((rt != '0) && (total_q != '0) && (rt != total_q)) ||
		(!dl_failed && (rb < bytes_q)) ||
		((t_eff != '0) && (b_eff > t_eff));

	assign div_b = (phase_q == PH_DOWN) ? b_eff : resume_q;
	assign div_t = (phase_q == PH_DOWN) ? t_eff : rt;

	upd_pct_div #(
		.SIZE_BITS(SIZE_BITS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num_b (div_b),
		.den_t (div_t),
		.done  (stat.div_done),
		.pct   (pct)
	);

	assign prog_max = (pct > progress_q) ? pct : progress_q;

	always_comb begin
		phase_n   = phase_q;
		err_n     = err_q;
		last_n    = last_q;
		resume_n  = resume_q;
		bytes_n   = bytes_q;
		total_n   = total_q;
		prog_n    = progress_q;
		acc       = 1'b0;
		fail      = 1'b0;
		fail_code = E_NONE;
		case (item_q.opcode)
			OP_BEGIN: begin
				if (busy_now) begin
					last_n = E_BUSY;
				end else begin
					err_n    = E_NONE;
					resume_n = '0;
					bytes_n  = '0;
					total_n  = '0;
					prog_n   = '0;
					if (!item_q.request_valid) begin
						phase_n = PH_ERROR;
						err_n   = E_INVALID_REQ;
						last_n  = E_INVALID_REQ;
					end else begin
						phase_n  = PH_CHECK;
						resume_n = ro;
						bytes_n  = ro;
						last_n   = E_NONE;
						acc      = 1'b1;
					end
				end
			end
			OP_STEP: begin
				case (phase_q)
					PH_CHECK: begin
						if (!item_q.transport_ok) begin
							fail      = 1'b1;
							fail_code = E_CHECK;
						end else if ((rt != '0) && (resume_q > rt)) begin
							fail      = 1'b1;
							fail_code = E_INVALID_RESUME;
						end else begin
							acc     = 1'b1;
							total_n = rt;
							bytes_n = resume_q;
							if (rt != '0) begin
								prog_n = prog_max;
							end
							if ((rt != '0) && (resume_q == rt)) begin
								prog_n  = PCT_FULL;
								phase_n = PH_VERIFY;
							end else begin
								phase_n = PH_DOWN;
							end
						end
					end
					PH_DOWN: begin
						fail_code = E_DOWNLOAD;
						if (early_fail) begin
							fail = 1'b1;
						end else begin
							acc     = 1'b1;
							bytes_n = b_eff;
							if (t_eff != '0) begin
								total_n = t_eff;
								prog_n  = prog_max;
							end
							// failure after the progress update keeps it
							if (dl_failed) begin
								fail = 1'b1;
							end else if (item_q.download_result == DL_COMPLETE) begin
								if ((t_eff != '0) && (b_eff != t_eff)) begin
									fail = 1'b1;
								end else begin
									prog_n  = PCT_FULL;
									phase_n = PH_VERIFY;
								end
							end
						end
					end
					PH_VERIFY: begin
						if (!item_q.transport_ok) begin
							fail      = 1'b1;
							fail_code = E_VERIFY;
						end else begin
							acc     = 1'b1;
							phase_n = PH_APPLY;
						end
					end
					PH_APPLY: begin
						if (!item_q.transport_ok) begin
							fail      = 1'b1;
							fail_code = E_APPLY;
						end else begin
							acc     = 1'b1;
							prog_n  = PCT_FULL;
							phase_n = PH_DONE;
							last_n  = E_NONE;
						end
					end
					default: begin
					end
				endcase
			end
			OP_ABORT: begin
				if (busy_now) begin
					fail      = 1'b1;
					fail_code = E_ABORTED;
				end
			end
			default: begin
			end
		endcase
		abort_n = fail;
		if (fail) begin
			phase_n = PH_ERROR;
			err_n   = fail_code;
			last_n  = fail_code;
			// an abort that takes effect still counts as accepted
			acc     = (item_q.opcode == OP_ABORT);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			err_q      <= E_NONE;
			last_q     <= E_NONE;
			resume_q   <= '0;
			bytes_q    <= '0;
			total_q    <= '0;
			progress_q <= '0;
		end else if (cmd.commit) begin
			phase_q    <= phase_n;
			err_q      <= err_n;
			last_q     <= last_n;
			resume_q   <= resume_n;
			bytes_q    <= bytes_n;
			total_q    <= total_n;
			progress_q <= prog_n;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_q <= req_data;
		end
		if (cmd.commit) begin
			rsp_q.accepted         <= acc;
			rsp_q.phase            <= phase_n;
			rsp_q.error_code       <= err_n;
			rsp_q.last_error_code  <= last_n;
			rsp_q.bytes_done       <= FIELD_W'(bytes_n);
			rsp_q.image_total      <= FIELD_W'(total_n);
			rsp_q.progress_percent <= prog_n;
			rsp_q.busy_flag        <= busy_n;
			rsp_q.transport_abort  <= abort_n;
		end
	end

	assign rsp_data = rsp_q;

	`UDS_NEVER(a_prog_range, clk, arst_n, progress_q > PCT_FULL)
	`UDS_ASSERT(a_busy_no_err, clk, arst_n, busy_now |-> (err_q == E_NONE))
	`UDS_ASSERT(a_abort_err, clk, arst_n, (cmd.commit && abort_n) |=> (phase_q == PH_ERROR))

endmodule

FILE: design/upd_ctrl.sv
// ---------------------------------------------------------------------------
// Update sequencer controller
// Sequences item capture, progress division and result hand-off.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module upd_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	input  upd_seq_pkg::dp_stat_t stat,
	output upd_seq_pkg::dp_cmd_t  cmd
);
	import upd_seq_pkg::*;

	ctrl_state_t state_q, state_n;
	logic        out_valid_q;
	logic        slot_free;

	assign slot_free = !out_valid_q || rsp_ready;

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_n = ST_PREP;
				end
			end
			ST_PREP: state_n = ST_DIV;
			ST_DIV: begin
				if (stat.div_done) begin
					state_n = ST_FIN;
				end
			end
			ST_FIN: begin
				if (slot_free) begin
					state_n = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready     = 1'b0;
		cmd.load_item = 1'b0;
		cmd.div_start = 1'b0;
		cmd.commit    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready     = 1'b1;
				cmd.load_item = req_valid;
			end
			ST_PREP: cmd.div_start = 1'b1;
			ST_DIV: begin
			end
			ST_FIN: cmd.commit = slot_free;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = out_valid_q;

	`UDS_ASSERT(a_rise_after_fin, clk, arst_n, $rose(out_valid_q) |-> $past(state_q == ST_FIN))
	`UDS_ASSERT(a_fin_holds, clk, arst_n, (state_q == ST_FIN && out_valid_q && !rsp_ready) |=> (state_q == ST_FIN))
	`UDS_ASSERT(a_done_in_div, clk, arst_n, stat.div_done |-> (state_q == ST_DIV))

endmodule

FILE: design/update_download_sequencer_top.sv
// ---------------------------------------------------------------------------
// Firmware update sequencer, top level
// Takes begin, step and abort commands and returns one status item each.
// ---------------------------------------------------------------------------
// Usage:
//   req carries one command item (begin, step or abort); rsp returns exactly
//   one status item per command: phase, error codes, byte counts, progress
//   percentage and a one-item abort pulse for the transport.
//   One command is processed at a time; a new item is taken only after the
//   previous one has been committed.
//   The progress divider is a serial restoring unit that yields one quotient
//   bit per cycle.
//   req.ready is high only while the controller is idle; a finished status
//   waits in the output register while the next command is taken in.
//   If rsp.ready stays low, the next command stops before commit and holds
//   its state until the output register frees up.
//   Reset (arst_n low) returns to idle with no error, zero sizes and zero
//   progress; no status item is pending after reset.
// ---------------------------------------------------------------------------
module update_download_sequencer_top #(
	parameter int unsigned SIZE_BITS = upd_seq_pkg::SIZE_BITS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	upd_req_if.sink   req,
	upd_rsp_if.source rsp
);
	import upd_seq_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     ready_int;
	logic     valid_int;

	upd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.req_ready(ready_int),
		.rsp_valid(valid_int),
		.rsp_ready(rsp.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	upd_dp #(
		.SIZE_BITS(SIZE_BITS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.req_data(req.data),
		.cmd     (cmd),
		.stat    (stat),
		.rsp_data(rsp.data)
	);

	assign req.ready = ready_int;
	assign rsp.valid = valid_int;

endmodule

FILE: bench/update_download_sequencer_top_test.sv
// ---------------------------------------------------------------------------
// Update download sequencer testbench
// Sends begin, step and abort commands over the command channel and checks
// every status item against an in-bench model of the update phases, error
// codes, byte counts and progress percentage. Directed cases come first,
// then random update sessions with random gaps and stalls on both sides.
// ---------------------------------------------------------------------------
module update_download_sequencer_top_test;
	import upd_seq_pkg::*;

	localparam logic [1:0] OP_UNUSED   = 2'd3;
	localparam logic [1:0] DL_RESERVED = 2'd3;
	localparam int unsigned RANDOM_ITEMS = 1300;

	logic clk;
	logic arst_n;

	upd_req_if cmd_bus ();
	upd_rsp_if status_bus ();

	update_download_sequencer_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (cmd_bus),
		.rsp    (status_bus)
	);

	// model of the sequencer
	phase_t      seq_phase;
	error_t      seq_err;
	error_t      seq_last_err;
	logic [31:0] seq_resume;
	logic [31:0] seq_bytes;
	logic [31:0] seq_total;
	logic [6:0]  seq_pct;
	logic        seq_abort;

	rsp_item_t expected_status[$];

	int unsigned sent_items;
	int unsigned effective_items;
	int unsigned checked_items;
	int unsigned mismatches;
	int unsigned updates_done;
	int unsigned abort_pulses;
	int          sink_hold_cycles;
	bit          gaps_on;
	bit          sink_stalls_on;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("*** FAILED ***");
		$finish;
	end

	function automatic logic run_active();
		return seq_phase >= PH_CHECK && seq_phase <= PH_APPLY;
	endfunction

	function automatic void clear_run();
		seq_err = E_NONE;
		seq_resume = '0;
		seq_bytes = '0;
		seq_total = '0;
		seq_pct = '0;
	endfunction

	function automatic logic [6:0] percent_of(input logic [31:0] b, input logic [31:0] t);
		longint unsigned scaled;
		if (b >= t)
			return PCT_FULL;
		scaled = 64'(b) * PCT_FULL / 64'(t);
		return scaled[6:0];
	endfunction

	function automatic void track_progress(input logic [31:0] b, input logic [31:0] t);
		logic [6:0] p;
		seq_bytes = b;
		if (t != 0) begin
			seq_total = t;
			p = percent_of(b, t);
			if (p > seq_pct)
				seq_pct = p;
		end
	endfunction

	function automatic logic enter_fault(input error_t code);
		seq_abort = 1'b1;
		seq_phase = PH_ERROR;
		seq_err = code;
		seq_last_err = code;
		return 1'b0;
	endfunction

	function automatic logic apply_step(input req_item_t c);
		logic [31:0] t;
		logic [31:0] b;
		logic        failed;
		case (seq_phase)
			PH_CHECK: begin
				if (!c.transport_ok)
					return enter_fault(E_CHECK);
				if (c.reported_total != 0 && seq_resume > c.reported_total)
					return enter_fault(E_INVALID_RESUME);
				seq_total = c.reported_total;
				track_progress(seq_resume, c.reported_total);
				if (c.reported_total != 0 && seq_resume == c.reported_total) begin
					seq_pct = PCT_FULL;
					seq_phase = PH_VERIFY;
				end else begin
					seq_phase = PH_DOWN;
				end
				return 1'b1;
			end
			PH_DOWN: begin
				t = seq_total;
				failed = c.download_result >= DL_FAILED;
				if (c.reported_total != 0) begin
					if (t != 0 && c.reported_total != t)
						return enter_fault(E_DOWNLOAD);
					t = c.reported_total;
				end
				// a failed download may report fewer bytes; the count just holds
				b = (c.reported_bytes < seq_bytes) ? seq_bytes : c.reported_bytes;
				if (!failed && c.reported_bytes < seq_bytes)
					return enter_fault(E_DOWNLOAD);
				if (t != 0 && b > t)
					return enter_fault(E_DOWNLOAD);
				track_progress(b, t);
				if (failed)
					return enter_fault(E_DOWNLOAD);
				if (c.download_result == DL_COMPLETE) begin
					if (t != 0 && b != t)
						return enter_fault(E_DOWNLOAD);
					seq_pct = PCT_FULL;
					seq_phase = PH_VERIFY;
				end
				return 1'b1;
			end
			PH_VERIFY: begin
				if (!c.transport_ok)
					return enter_fault(E_VERIFY);
				seq_phase = PH_APPLY;
				return 1'b1;
			end
			PH_APPLY: begin
				if (!c.transport_ok)
					return enter_fault(E_APPLY);
				seq_pct = PCT_FULL;
				seq_phase = PH_DONE;
				seq_last_err = E_NONE;
				updates_done++;
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	function automatic rsp_item_t predict_status(input req_item_t c);
		rsp_item_t r;
		logic      acc;
		acc = 1'b0;
		seq_abort = 1'b0;
		case (c.opcode)
			OP_BEGIN: begin
				if (run_active()) begin
					seq_last_err = E_BUSY;
				end else if (!c.request_valid) begin
					clear_run();
					seq_phase = PH_ERROR;
					seq_err = E_INVALID_REQ;
					seq_last_err = E_INVALID_REQ;
				end else begin
					clear_run();
					seq_phase = PH_CHECK;
					seq_resume = c.resume_offset;
					seq_bytes = c.resume_offset;
					seq_last_err = E_NONE;
					acc = 1'b1;
				end
			end
			OP_STEP: acc = apply_step(c);
			OP_ABORT: begin
				if (run_active()) begin
					void'(enter_fault(E_ABORTED));
					acc = 1'b1;
				end
			end
			default: ;
		endcase
		if (seq_abort)
			abort_pulses++;
		r.accepted = acc;
		r.phase = seq_phase;
		r.error_code = seq_err;
		r.last_error_code = seq_last_err;
		r.bytes_done = seq_bytes;
		r.image_total = seq_total;
		r.progress_percent = seq_pct;
		r.busy_flag = run_active();
		r.transport_abort = seq_abort;
		return r;
	endfunction

	function automatic req_item_t noise_cmd(input logic [1:0] op);
		req_item_t c;
		c.opcode = op;
		c.request_valid = 1'($urandom_range(0, 1));
		c.resume_offset = $urandom;
		c.transport_ok = 1'($urandom_range(0, 1));
		c.reported_total = $urandom;
		c.reported_bytes = $urandom;
		c.download_result = 2'($urandom_range(DL_PROGRESS, DL_RESERVED));
		return c;
	endfunction

	function automatic req_item_t begin_cmd(input logic ok, input logic [31:0] offset);
		req_item_t c;
		c = noise_cmd(OP_BEGIN);
		c.request_valid = ok;
		c.resume_offset = offset;
		return c;
	endfunction

	function automatic req_item_t step_cmd(input logic ok, input logic [31:0] total,
			input logic [31:0] bytes, input logic [1:0] result);
		req_item_t c;
		c = noise_cmd(OP_STEP);
		c.transport_ok = ok;
		c.reported_total = total;
		c.reported_bytes = bytes;
		c.download_result = result;
		return c;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 40)
			$display("MISMATCH at %0t: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("status %0d %s = %0h, expected %0h",
				checked_items, name, got, want));
	endtask

	task automatic compare_status(input rsp_item_t got);
		rsp_item_t want;
		if (expected_status.size() == 0) begin
			report_mismatch($sformatf("status item with none pending (phase %0d)", got.phase));
			return;
		end
		want = expected_status.pop_front();
		checked_items++;
		check_field("accepted", 32'(got.accepted), 32'(want.accepted));
		check_field("phase", 32'(got.phase), 32'(want.phase));
		check_field("error_code", 32'(got.error_code), 32'(want.error_code));
		check_field("last_error_code", 32'(got.last_error_code),
			32'(want.last_error_code));
		check_field("bytes_done", got.bytes_done, want.bytes_done);
		check_field("image_total", got.image_total, want.image_total);
		check_field("progress_percent", 32'(got.progress_percent),
			32'(want.progress_percent));
		check_field("busy_flag", 32'(got.busy_flag), 32'(want.busy_flag));
		check_field("transport_abort", 32'(got.transport_abort),
			32'(want.transport_abort));
	endtask

	// called on a clock edge; returns on the edge the item is taken, valid left high
	task automatic send_command(input req_item_t c);
		int        gap;
		rsp_item_t want;
		gap = gaps_on ? $urandom_range(0, 8) : 0;
		if (gap > 0) begin
			cmd_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_bus.valid <= 1'b1;
		cmd_bus.data <= c;
		do @(posedge clk); while (cmd_bus.ready !== 1'b1);
		want = predict_status(c);
		expected_status.push_back(want);
		sent_items++;
		if (want.accepted || want.transport_abort || c.opcode == OP_BEGIN)
			effective_items++;
	endtask

	task automatic settle_all(input int extra);
		int guard;
		guard = 0;
		cmd_bus.valid <= 1'b0;
		while (expected_status.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (extra) @(posedge clk);
	endtask

	task automatic maybe_noise();
		if ($urandom_range(0, 19) == 0)
			send_command(noise_cmd(2'($urandom_range(OP_BEGIN, OP_UNUSED))));
	endtask

	// mostly well-formed update: begin, check, downloads, verify, apply
	task automatic run_update_session();
		logic [31:0] total;
		logic [31:0] pos;
		logic [31:0] rb;
		logic [31:0] told;
		logic [1:0]  res;
		int          n_dl;
		case ($urandom_range(0, 4))
			0: total = '0;
			1: total = $urandom_range(1, 200);
			2: total = $urandom_range(1, 100000);
			3: total = $urandom;
			default: total = 32'hFFFF_FFFF - $urandom_range(0, 3);
		endcase
		case ($urandom_range(0, 7))
			0: pos = total;
			1: pos = $urandom;
			2, 3: pos = (total == 0) ? $urandom_range(0, 1000) : $urandom_range(0, total);
			default: pos = '0;
		endcase
		send_command(begin_cmd($urandom_range(0, 15) != 0, pos));
		maybe_noise();
		told = ($urandom_range(0, 4) == 0) ? '0 : total;
		send_command(step_cmd($urandom_range(0, 15) != 0, told, $urandom,
			2'($urandom_range(DL_PROGRESS, DL_RESERVED))));
		n_dl = $urandom_range(1, 5);
		for (int i = 0; i < n_dl; i++) begin
			maybe_noise();
			if (total == 0)
				rb = pos + $urandom_range(0, 5000);
			else if (i == n_dl - 1)
				rb = total;
			else
				rb = (total >= pos) ? pos + $urandom_range(0, total - pos) : pos;
			res = (i == n_dl - 1) ? DL_COMPLETE : DL_PROGRESS;
			told = ($urandom_range(0, 3) == 0) ? '0 : total;
			case ($urandom_range(0, 39))
				0: told = $urandom;
				1: rb = pos - $urandom_range(1, 50);
				2: res = DL_FAILED;
				3: res = DL_RESERVED;
				default: ;
			endcase
			send_command(step_cmd(1'($urandom_range(0, 1)), told, rb, res));
			pos = rb;
		end
		maybe_noise();
		send_command(step_cmd($urandom_range(0, 15) != 0, $urandom, $urandom,
			2'($urandom_range(DL_PROGRESS, DL_RESERVED))));
		send_command(step_cmd($urandom_range(0, 15) != 0, $urandom, $urandom,
			2'($urandom_range(DL_PROGRESS, DL_RESERVED))));
	endtask

	task automatic test_idle_commands();
		send_command(noise_cmd(OP_STEP));
		send_command(noise_cmd(OP_ABORT));
		send_command(noise_cmd(OP_UNUSED));
		settle_all(20);
	endtask

	task automatic test_complete_update();
		send_command(begin_cmd(1'b1, '0));
		// check with unknown size, size learned during download
		send_command(step_cmd(1'b1, '0, $urandom, DL_PROGRESS));
		send_command(step_cmd(1'($urandom_range(0, 1)), '0, '0, DL_PROGRESS));
		send_command(step_cmd(1'($urandom_range(0, 1)), 32'd1000, 32'd250, DL_PROGRESS));
		send_command(begin_cmd(1'b1, $urandom));
		send_command(step_cmd(1'($urandom_range(0, 1)), '0, 32'd1000, DL_COMPLETE));
		send_command(step_cmd(1'b1, $urandom, $urandom, DL_FAILED));
		send_command(step_cmd(1'b1, $urandom, $urandom, DL_RESERVED));
		send_command(noise_cmd(OP_STEP));
		send_command(noise_cmd(OP_ABORT));
		settle_all(20);
	endtask

	task automatic test_failure_paths();
		send_command(begin_cmd(1'b0, $urandom));
		send_command(noise_cmd(OP_STEP));
		send_command(begin_cmd(1'b1, 32'hFFFF_FFFF));
		send_command(step_cmd(1'b1, 32'd5, $urandom, DL_COMPLETE));
		// resume equal to total skips the download
		send_command(begin_cmd(1'b1, 32'd100));
		send_command(step_cmd(1'b1, 32'd100, $urandom, DL_PROGRESS));
		send_command(step_cmd(1'b0, $urandom, $urandom, DL_COMPLETE));
		send_command(begin_cmd(1'b1, $urandom));
		send_command(step_cmd(1'b0, $urandom, $urandom, DL_PROGRESS));
		send_command(begin_cmd(1'b1, '0));
		send_command(step_cmd(1'b1, 32'hFFFF_FFFF, '0, DL_PROGRESS));
		send_command(step_cmd(1'b1, '0, 32'hFFFF_FFFF, DL_RESERVED));
		send_command(begin_cmd(1'b1, 32'd7));
		send_command(noise_cmd(OP_ABORT));
		settle_all(20);
	endtask

	// receiver holds off while commands keep coming back to back
	task automatic test_output_backpressure();
		gaps_on = 1'b0;
		sink_hold_cycles = 300;
		repeat (3) run_update_session();
		settle_all(20);
		gaps_on = 1'b1;
	endtask

	task automatic test_random_sessions();
		int unsigned stop_at;
		stop_at = sent_items + RANDOM_ITEMS;
		while (sent_items < stop_at) begin
			if ($urandom_range(0, 7) == 0)
				gaps_on = !gaps_on;
			if ($urandom_range(0, 7) == 0)
				sink_stalls_on = !sink_stalls_on;
			run_update_session();
		end
		gaps_on = 1'b1;
		sink_stalls_on = 1'b1;
		settle_all(20);
	endtask

	initial begin : status_sink
		int pause;
		status_bus.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (sink_hold_cycles > 0) begin
				pause = sink_hold_cycles;
				sink_hold_cycles = 0;
				status_bus.ready <= 1'b0;
				repeat (pause) @(posedge clk);
			end
			pause = sink_stalls_on ? $urandom_range(0, 8) : 0;
			if (pause > 0) begin
				status_bus.ready <= 1'b0;
				repeat (pause) @(posedge clk);
			end
			status_bus.ready <= 1'b1;
			do @(posedge clk); while (status_bus.valid !== 1'b1);
			compare_status(status_bus.data);
		end
	end

	initial begin : run
		arst_n <= 1'b0;
		cmd_bus.valid <= 1'b0;
		cmd_bus.data <= '0;
		seq_phase = PH_IDLE;
		seq_last_err = E_NONE;
		seq_abort = 1'b0;
		clear_run();
		gaps_on = 1'b1;
		sink_stalls_on = 1'b1;
		sink_hold_cycles = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_commands();
		test_complete_update();
		test_failure_paths();
		test_output_backpressure();
		test_random_sessions();

		settle_all(30);
		if (expected_status.size() != 0)
			report_mismatch($sformatf("%0d status items never arrived", expected_status.size()));
		$display("Sent %0d commands (%0d took effect), checked %0d status items.",
			sent_items, effective_items, checked_items);
		$display("Updates run to done: %0d, transport aborts: %0d, mismatches: %0d.",
			updates_done, abort_pulses, mismatches);
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

FILE: files.f
+incdir+design
design/upd_seq_pkg.sv
design/upd_if.sv
design/upd_pct_div.sv
design/upd_dp.sv
design/upd_ctrl.sv
design/update_download_sequencer_top.sv
bench/update_download_sequencer_top_test.sv
